// ===== hw/rtl/rcha_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes for the reference-counted handle allocator.
// No dependencies; imported by refcounted_handle_allocator.
package rcha_pkg;

  // Operation code carried by an input word
  typedef logic [1:0] func_t;
  localparam func_t FUNC_CREATE  = 2'd0;
  localparam func_t FUNC_OPEN    = 2'd1;
  localparam func_t FUNC_RELEASE = 2'd2;

  // Status code carried by a result word
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOFREE    = 2'd1;
  localparam status_t ST_NOTLIVE   = 2'd2;
  localparam status_t ST_SATURATED = 2'd3;

endpackage

// ===== hw/rtl/refcounted_handle_allocator.sv =====
`timescale 1ns / 1ps
// Reference-counted handle allocator: handle table in one synchronous memory
// plus free-list head and high-water mark registers. Depends on rcha_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready | in_func, in_handle
//  out_    | output    | out_valid/out_ready | out_status, out_granted_handle,
//          |           |                     | out_count_after, out_was_freed
//
// Each word: the accept edge reads the table entry into a register, and in
// the S_EXEC state the entry is then modified and written back and the
// result register is loaded. The table's registered read sets this split.
// A new word is taken while a result waits; the write-back cycle holds only
// while the result register is still full and not being drained.
// Reset is synchronous and ready at once: entries at or above the high-water mark
// read as their reset value, so the table needs no clearing pass.
module refcounted_handle_allocator #(
  parameter int HANDLE_COUNT = 1024,
  parameter int COUNT_WIDTH  = 16,
  localparam int HANDLE_W    = $clog2(HANDLE_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rcha_pkg::func_t       in_func,
  input  logic [HANDLE_W-1:0]   in_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rcha_pkg::status_t     out_status,
  output logic [HANDLE_W-1:0]   out_granted_handle,
  output logic [COUNT_WIDTH-1:0] out_count_after,
  output logic                  out_was_freed
);
  import rcha_pkg::*;

  // Link values hold a handle, zero (never used) or the all-ones end marker
  localparam int LINK_W  = HANDLE_W + 1;
  localparam int ENTRY_W = LINK_W + 1 + COUNT_WIDTH;
  localparam int LIVE_B  = COUNT_WIDTH;
  localparam int LINK_LO = COUNT_WIDTH + 1;

  localparam logic [LINK_W-1:0]      LINK_END  = {LINK_W{1'b1}};
  localparam logic [LINK_W-1:0]      LAST_IDX  = LINK_W'(HANDLE_COUNT - 1);
  localparam logic [LINK_W-1:0]      COUNT_LIM = LINK_W'(HANDLE_COUNT);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state_r, state_nxt;
  logic [LINK_W-1:0]      free_head_r, free_head_nxt;
  logic [LINK_W-1:0]      hwm_r, hwm_nxt;
  func_t                  func_r;
  logic [HANDLE_W-1:0]    handle_r;

  logic [ENTRY_W-1:0]     mem [HANDLE_COUNT];
  logic [ENTRY_W-1:0]     rd_data_r;
  logic [HANDLE_W-1:0]    rd_addr;
  logic                   wr_en;
  logic [HANDLE_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]     wr_data;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0]    out_handle_r, out_handle_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r, out_count_nxt;
  logic                   out_freed_r, out_freed_nxt;

  logic                   accept;
  logic                   exec_go;
  logic [LINK_W-1:0]      h_ext;
  logic [LINK_W-1:0]      rd_link;
  logic                   rd_live;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [LINK_W-1:0]      pop_link;
  logic                   head_empty;
  logic                   is_live;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Read address: head for a create, the given handle otherwise
  assign rd_addr = (in_func == FUNC_CREATE) ? free_head_r[HANDLE_W-1:0] : in_handle;

  // Table memory: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Split the entry read for this word
  assign rd_link  = rd_data_r[ENTRY_W-1:LINK_LO];
  assign rd_live  = rd_data_r[LIVE_B];
  assign rd_count = rd_data_r[COUNT_WIDTH-1:0];
  assign h_ext    = {1'b0, handle_r};

  // Entries at or above the high-water mark were never written
  assign head_empty = (free_head_r >= COUNT_LIM) || (free_head_r == '0);
  assign pop_link   = (free_head_r >= hwm_r) ?
                      ((free_head_r == LAST_IDX) ? LINK_END : '0) : rd_link;
  assign is_live    = (handle_r != '0) && (h_ext < COUNT_LIM) && (h_ext < hwm_r) && rd_live;

  // Modify the entry, update the list head and form the result word
  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    hwm_nxt        = hwm_r;
    wr_en          = 1'b0;
    wr_addr        = handle_r;
    wr_data        = rd_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_count_nxt  = out_count_r;
    out_freed_nxt  = out_freed_r;

    if (accept) begin
      state_nxt = S_EXEC;
    end

    if (exec_go) begin
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_handle_nxt = handle_r;
      out_count_nxt  = '0;
      out_freed_nxt  = 1'b0;
      if (func_r == FUNC_CREATE) begin
        if (head_empty) begin
          out_status_nxt = ST_NOFREE;
          out_handle_nxt = '0;
        end else begin
          free_head_nxt  = (pop_link == '0) ? free_head_r + LINK_W'(1) : pop_link;
          if (free_head_r >= hwm_r) begin
            hwm_nxt = free_head_r + LINK_W'(1);
          end
          wr_en          = 1'b1;
          wr_addr        = free_head_r[HANDLE_W-1:0];
          wr_data        = {pop_link, 1'b1, COUNT_WIDTH'(1)};
          out_status_nxt = ST_OK;
          out_handle_nxt = free_head_r[HANDLE_W-1:0];
          out_count_nxt  = COUNT_WIDTH'(1);
        end
      end else if (!is_live || (func_r != FUNC_OPEN && func_r != FUNC_RELEASE)) begin
        out_status_nxt = ST_NOTLIVE;
      end else if (func_r == FUNC_OPEN) begin
        if (rd_count == COUNT_MAX) begin
          out_status_nxt = ST_SATURATED;
          out_count_nxt  = rd_count;
        end else begin
          wr_en          = 1'b1;
          wr_data        = {rd_link, 1'b1, rd_count + COUNT_WIDTH'(1)};
          out_status_nxt = ST_OK;
          out_count_nxt  = rd_count + COUNT_WIDTH'(1);
        end
      end else begin
        // Release: drop one reference, push the handle on the list at zero
        out_status_nxt = ST_OK;
        wr_en          = 1'b1;
        if (rd_count <= COUNT_WIDTH'(1)) begin
          wr_data       = {free_head_r, 1'b0, COUNT_WIDTH'(0)};
          free_head_nxt = h_ext;
          out_freed_nxt = 1'b1;
        end else begin
          wr_data       = {rd_link, 1'b1, rd_count - COUNT_WIDTH'(1)};
          out_count_nxt = rd_count - COUNT_WIDTH'(1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= LINK_W'(1);
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture the input word, hold the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      handle_r <= in_handle;
    end
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_count_r  <= out_count_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_handle = out_handle_r;
  assign out_count_after    = out_count_r;
  assign out_was_freed      = out_freed_r;

  // An accepted word always moves the sequencer to its write-back cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted word did not enter write-back");

  // The list head never points at the reserved entry
  a_head_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r != '0)
    else $error("free-list head is zero");

  // The high-water mark never passes the table size
  a_hwm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r <= COUNT_LIM)
    else $error("high-water mark beyond table");

  // A freeing release always reports a zero count
  a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_freed_r) |-> (out_count_r == '0 && out_status_r == ST_OK))
    else $error("freed handle with nonzero count");

endmodule
